@@ hw/rtl/bsds_pkg.sv @@
// shared types and constants for the bitmap set difference core
// no dependencies; imported by controller, datapath, top level and checker
package bsds_pkg;

  localparam int IN_DATA_W  = 24;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 40;
  localparam int OUT_USER_W = 1;
  localparam int VALUE_W    = 17;
  localparam int COUNT_W    = 18;

  localparam logic [1:0] FUNC_MARK  = 2'd0;
  localparam logic [1:0] FUNC_OFFER = 2'd1;
  localparam logic [1:0] FUNC_READ  = 2'd2;
  localparam logic [1:0] FUNC_CLEAR = 2'd3;

  typedef struct packed {
    logic latch_in;
    logic clr_start;
    logic clr_step;
    logic rmw_rd;
    logic rmw_wr;
    logic scan_start;
    logic scan_rd;
    logic scan_ev;
    logic scan_end;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic clr_done;
    logic pos_end;
    logic hit;
    logic second;
    logic out_free;
  } sts_t;

endpackage

@@ hw/rtl/bsds_ram.sv @@
// generic single write port ram with registered read
// no dependencies
module bsds_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hw/rtl/bsds_ctrl.sv @@
// controller state machine: clearing pass, read-modify-write and scan sequencing
// depends on bsds_pkg
module bsds_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic [1:0]    in_func,
  output logic          in_ready,
  input  bsds_pkg::sts_t sts,
  output bsds_pkg::cmd_t cmd
);
  import bsds_pkg::*;

  localparam logic [2:0] S_CLEAR   = 3'd0;
  localparam logic [2:0] S_IDLE    = 3'd1;
  localparam logic [2:0] S_RMW_RD  = 3'd2;
  localparam logic [2:0] S_RMW_WR  = 3'd3;
  localparam logic [2:0] S_SCAN_RD = 3'd4;
  localparam logic [2:0] S_SCAN_EV = 3'd5;
  localparam logic [2:0] S_RESULT  = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_done) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.latch_in = 1'b1;
          case (in_func)
            FUNC_CLEAR: begin
              cmd.clr_start = 1'b1;
              state_next    = S_CLEAR;
            end
            FUNC_READ: begin
              cmd.scan_start = 1'b1;
              state_next     = S_SCAN_RD;
            end
            default: begin
              state_next = S_RMW_RD;
            end
          endcase
        end
      end
      S_RMW_RD: begin
        cmd.rmw_rd = 1'b1;
        state_next = S_RMW_WR;
      end
      S_RMW_WR: begin
        cmd.rmw_wr = 1'b1;
        state_next = S_IDLE;
      end
      S_SCAN_RD: begin
        if (sts.pos_end) begin
          cmd.scan_end = 1'b1;
          state_next   = S_RESULT;
        end else begin
          cmd.scan_rd = 1'b1;
          state_next  = S_SCAN_EV;
        end
      end
      S_SCAN_EV: begin
        cmd.scan_ev = 1'b1;
        if (sts.hit && sts.second) begin
          state_next = S_RESULT;
        end else begin
          state_next = S_SCAN_RD;
        end
      end
      S_RESULT: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

endmodule

@@ hw/rtl/bsds_dp.sv @@
// datapath: bitmap ram, count, cursor, word search and output register
// depends on bsds_pkg and bsds_ram
module bsds_dp #(
  parameter int VALUE_BITS = 17
) (
  input  logic                                clk,
  input  logic                                rst,
  input  bsds_pkg::cmd_t                      cmd,
  output bsds_pkg::sts_t                      sts,
  input  logic [bsds_pkg::IN_DATA_W-1:0]      in_data,
  input  logic [bsds_pkg::IN_USER_W-1:0]      in_user,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [bsds_pkg::OUT_DATA_W-1:0]     out_data,
  output logic [bsds_pkg::OUT_USER_W-1:0]     out_user,
  output logic                                out_last
);
  import bsds_pkg::*;

  localparam int OFF_W  = (VALUE_BITS > 5) ? 5 : VALUE_BITS - 2;
  localparam int WORD_W = 1 << OFF_W;
  localparam int ADDR_W = VALUE_BITS - OFF_W;
  localparam int DEPTH  = 1 << ADDR_W;
  localparam int VEXT_W = (VALUE_BITS > VALUE_W) ? VALUE_BITS : VALUE_W;
  localparam int CEXT_W = (VALUE_BITS + 1 > COUNT_W) ? VALUE_BITS + 1 : COUNT_W;

  logic [1:0]            func;
  logic [VALUE_BITS-1:0] val;
  logic [VALUE_BITS:0]   count;
  logic [VALUE_BITS:0]   cursor;
  logic [VALUE_BITS:0]   pos;
  logic                  second;
  logic [VALUE_BITS-1:0] found;
  logic                  res_valid;
  logic                  res_last;
  logic [ADDR_W-1:0]     clr_addr;

  logic                  we;
  logic [ADDR_W-1:0]     waddr;
  logic [2*WORD_W-1:0]   wdata;
  logic [ADDR_W-1:0]     raddr;
  logic [2*WORD_W-1:0]   rdata;

  logic [VEXT_W-1:0]     in_val_ext;
  logic [WORD_W-1:0]     t_old;
  logic [WORD_W-1:0]     b_old;
  logic [WORD_W-1:0]     val_bit;
  logic                  fresh;
  logic [2*WORD_W-1:0]   rmw_data;
  logic [WORD_W-1:0]     masked;
  logic [OFF_W-1:0]      hit_off;
  logic                  hit;
  logic [VALUE_BITS-1:0] hit_value;
  logic [VALUE_BITS:0]   hit_next;
  logic [VALUE_BITS:0]   skip_next;
  logic [VEXT_W-1:0]     found_ext;
  logic [CEXT_W-1:0]     count_ext;

  bsds_ram #(
    .WIDTH (2 * WORD_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign in_val_ext = VEXT_W'(in_data[VALUE_W-1:0]);

  // low half holds taken bits, high half holds b bits
  assign t_old   = rdata[WORD_W-1:0];
  assign b_old   = rdata[2*WORD_W-1:WORD_W];
  assign val_bit = WORD_W'(1) << val[OFF_W-1:0];
  assign fresh   = ~|((t_old | b_old) & val_bit);

  always_comb begin
    if (func == FUNC_MARK) begin
      rmw_data = {b_old | val_bit, t_old};
    end else if (fresh) begin
      rmw_data = {b_old, t_old | val_bit};
    end else begin
      rmw_data = rdata;
    end
  end

  assign we    = cmd.clr_step | cmd.rmw_wr;
  assign waddr = cmd.clr_step ? clr_addr : val[VALUE_BITS-1:OFF_W];
  assign wdata = cmd.clr_step ? '0 : rmw_data;
  assign raddr = cmd.scan_rd ? pos[VALUE_BITS-1:OFF_W] : val[VALUE_BITS-1:OFF_W];

  // lowest taken bit at or above the scan position within the word
  assign masked = t_old & ({WORD_W{1'b1}} << pos[OFF_W-1:0]);

  always_comb begin
    hit_off = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (masked[i]) begin
        hit_off = OFF_W'(i);
      end
    end
  end

  assign hit       = |masked;
  assign hit_value = {pos[VALUE_BITS-1:OFF_W], hit_off};
  assign hit_next  = {1'b0, hit_value} + (VALUE_BITS + 1)'(1);
  assign skip_next = {(ADDR_W + 1)'(pos[VALUE_BITS-1:OFF_W]) + (ADDR_W + 1)'(1),
                      {OFF_W{1'b0}}};

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      cursor   <= '0;
      clr_addr <= '0;
      second   <= 1'b0;
    end else begin
      if (cmd.clr_start) begin
        count    <= '0;
        cursor   <= '0;
        clr_addr <= '0;
      end else if (cmd.clr_step) begin
        clr_addr <= clr_addr + ADDR_W'(1);
      end
      if (cmd.rmw_wr && func == FUNC_OFFER && fresh) begin
        count <= count + (VALUE_BITS + 1)'(1);
      end
      if (cmd.scan_start) begin
        second <= 1'b0;
      end else if (cmd.scan_ev && hit) begin
        second <= 1'b1;
      end
      if (cmd.scan_ev && hit && !second) begin
        cursor <= hit_next;
      end else if (cmd.scan_end && !second) begin
        cursor <= {1'b1, {VALUE_BITS{1'b0}}};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      func <= in_user[1:0];
      val  <= in_val_ext[VALUE_BITS-1:0];
    end
    if (cmd.scan_start) begin
      pos <= cursor;
    end else if (cmd.scan_ev) begin
      pos <= hit ? hit_next : skip_next;
    end
    if (cmd.scan_ev && hit && !second) begin
      found     <= hit_value;
      res_valid <= 1'b1;
    end else if (cmd.scan_end && !second) begin
      found     <= '0;
      res_valid <= 1'b0;
    end
    if (cmd.scan_ev && hit && second) begin
      res_last <= 1'b0;
    end else if (cmd.scan_end) begin
      res_last <= 1'b1;
    end
  end

  assign found_ext = VEXT_W'(found);
  assign count_ext = CEXT_W'(count);

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_data <= OUT_DATA_W'({count_ext[COUNT_W-1:0], found_ext[VALUE_W-1:0]});
      out_user <= res_valid;
      out_last <= res_last;
    end
  end

  assign sts.clr_done = &clr_addr;
  assign sts.pos_end  = pos[VALUE_BITS];
  assign sts.hit      = hit;
  assign sts.second   = second;
  assign sts.out_free = !out_valid || out_ready;

endmodule

@@ hw/rtl/bitmap_set_difference_sorted_core.sv @@
// top level of the bitmap set difference core (A minus B, distinct, ascending)
// depends on bsds_pkg, bsds_ctrl and bsds_dp
//
// input stream: tuser carries the function (mark b member, offer a element,
// read next, clear all), tdata carries the value. only read transfers give a
// result on the output stream: value and distinct count in tdata, found flag
// in tuser, tlast set when no taken value remains above the one returned.
// the bitmaps live in one ram of 64-bit words (32 taken and 32 b bits side by side).
// mark and offer do a ram read then a ram write. clear writes one ram word
// per cycle. a read scans one ram word at a time up to the result and on to
// the next taken value, and then waits until the output register is free.
// reset starts the same clearing pass, with s_tready low. a stalled
// receiver holds the result in the output register; the next item is
// taken meanwhile, and a later read waits for it.
module bitmap_set_difference_sorted_core #(
  parameter int VALUE_BITS = 17
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [bsds_pkg::IN_DATA_W-1:0]      s_tdata,   // value
  input  logic [bsds_pkg::IN_USER_W-1:0]      s_tuser,   // func
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [bsds_pkg::OUT_DATA_W-1:0]     m_tdata,   // result_value, taken_count
  output logic [bsds_pkg::OUT_USER_W-1:0]     m_tuser,   // result_valid
  output logic                                m_tlast
);
  import bsds_pkg::*;

  cmd_t cmd;
  sts_t sts;

  bsds_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_func  (s_tuser[1:0]),
    .in_ready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  bsds_dp #(
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (s_tdata),
    .in_user   (s_tuser),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (m_tdata),
    .out_user  (m_tuser),
    .out_last  (m_tlast)
  );

endmodule

@@ hw/rtl/bsds_checker.sv @@
// port-level checks for the bitmap set difference core
// depends on bsds_pkg; bound to bitmap_set_difference_sorted_core below
module bsds_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                s_tvalid,
  input logic                                s_tready,
  input logic [bsds_pkg::IN_DATA_W-1:0]      s_tdata,
  input logic [bsds_pkg::IN_USER_W-1:0]      s_tuser,
  input logic                                m_tvalid,
  input logic                                m_tready,
  input logic [bsds_pkg::OUT_DATA_W-1:0]     m_tdata,
  input logic [bsds_pkg::OUT_USER_W-1:0]     m_tuser,
  input logic                                m_tlast
);
  import bsds_pkg::*;

  // clearing pass follows reset
  a_reset_clear: assert property (@(posedge clk) rst |=> !s_tready)
    else $error("input ready during clearing pass after reset");

  // every accepted item keeps the block busy in the cycle after it is taken
  a_busy_after: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input ready right after a transfer");

  // exhausted scan gives zero value and last
  a_exhaust: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser[0]) |-> (m_tlast && m_tdata[VALUE_W-1:0] == '0))
    else $error("exhausted result not zero and last");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
    else $error("stalled result changed");

endmodule

bind bitmap_set_difference_sorted_core bsds_checker u_bsds_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);

@@ test/tb_bitmap_set_difference_sorted_core.sv @@
// testbench for bitmap_set_difference_sorted_core: directed and random mark, offer, read and
// clear streams, checked against a bitmap predictor of the set difference held in the bench
// depends on bsds_pkg and the core; self-contained, no files or arguments
`timescale 1ns / 1ps

module tb_bitmap_set_difference_sorted_core;
  import bsds_pkg::*;

  localparam int MAP_SIZE    = 1 << VALUE_W;
  localparam int MAP_WORDS   = MAP_SIZE / 32;
  localparam int QUIET_LIMIT = 40000;
  localparam int TAIL_CYCLES = 9000;
  localparam int HOLD_CYCLES = 600;
  localparam int HOLD_AT     = 60;

  typedef struct packed {
    logic [1:0]         func;
    logic [VALUE_W-1:0] value;
  } set_item_t;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               found;
    logic               last;
    logic [COUNT_W-1:0] count;
  } diff_result_t;

  logic                  clk;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic [IN_USER_W-1:0]  s_tuser = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic [OUT_USER_W-1:0] m_tuser;
  logic                  m_tlast;

  set_item_t    items_to_send[$];
  diff_result_t due_results[$];

  bit [31:0]          b_words [MAP_WORDS];
  bit [31:0]          taken_words [MAP_WORDS];
  logic [COUNT_W-1:0] distinct_cnt;
  int                 scan_pos;

  int errors = 0;
  int sent_count = 0;
  int results_seen = 0;
  int quiet_cycles = 0;
  int hold_left = 0;
  bit held = 1'b0;
  bit s_took = 1'b0;

  bitmap_set_difference_sorted_core dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),   // value
    .s_tuser  (s_tuser),   // func
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),   // result_value, taken_count
    .m_tuser  (m_tuser),   // result_valid
    .m_tlast  (m_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void clear_sets();
    for (int i = 0; i < MAP_WORDS; i++) begin
      b_words[i] = '0;
      taken_words[i] = '0;
    end
    distinct_cnt = '0;
    scan_pos = 0;
  endfunction

  function automatic int next_taken_from(int from);
    int p;
    bit [31:0] w;
    p = from;
    while (p < MAP_SIZE) begin
      w = taken_words[p >> 5] >> (p & 31);
      if (w == 0) p = (p | 31) + 1;
      else if (w[0]) return p;
      else p++;
    end
    return MAP_SIZE;
  endfunction

  function automatic void step_set_difference(logic [1:0] f, logic [VALUE_W-1:0] v);
    int hit;
    diff_result_t r;
    case (f)
      FUNC_MARK: b_words[v[VALUE_W-1:5]][v[4:0]] = 1'b1;
      FUNC_OFFER: begin
        if (!b_words[v[VALUE_W-1:5]][v[4:0]] && !taken_words[v[VALUE_W-1:5]][v[4:0]]) begin
          taken_words[v[VALUE_W-1:5]][v[4:0]] = 1'b1;
          distinct_cnt++;
        end
      end
      FUNC_CLEAR: clear_sets();
      default: begin
        hit = next_taken_from(scan_pos);
        r.count = distinct_cnt;
        if (hit >= MAP_SIZE) begin
          scan_pos = MAP_SIZE;
          r.value = '0;
          r.found = 1'b0;
          r.last = 1'b1;
        end else begin
          scan_pos = hit + 1;
          r.value = hit[VALUE_W-1:0];
          r.found = 1'b1;
          r.last = next_taken_from(scan_pos) >= MAP_SIZE;
        end
        due_results.push_back(r);
      end
    endcase
  endfunction

  function automatic void add_item(logic [1:0] f, logic [VALUE_W-1:0] v);
    set_item_t it;
    it.func = f;
    it.value = v;
    items_to_send.push_back(it);
  endfunction

  function automatic bit idle_roll(int n, int lo, int hi);
    return (n < lo || n >= hi) && ($urandom_range(99) < 23);
  endfunction

  // one run: usually a clear, then one or two rounds of marks and offers in a window, each followed by reads
  task automatic build_run();
    int kind;
    int span;
    int base;
    int n;
    int reads;
    logic [1:0] f;
    logic [VALUE_W-1:0] v;
    if ($urandom_range(99) < 85) add_item(FUNC_CLEAR, VALUE_W'($urandom));
    kind = $urandom_range(9);
    span = $urandom_range(64, 4);
    if (kind < 7) begin
      base = $urandom_range(300, 0);
    end else if (kind < 9) begin
      base = MAP_SIZE - span - $urandom_range(100, 0);
    end else begin
      base = 0;
      span = MAP_SIZE;
    end
    repeat ($urandom_range(2, 1)) begin
      n = $urandom_range(24, 6);
      repeat (n) begin
        v = VALUE_W'(base + $urandom_range(span - 1, 0));
        add_item(($urandom_range(99) < 25) ? FUNC_MARK : FUNC_OFFER, v);
      end
      reads = $urandom_range(1) ? n + 2 : $urandom_range(n, 1);
      repeat (reads) add_item(FUNC_READ, VALUE_W'($urandom));
    end
    if ($urandom_range(9) == 0) begin
      repeat ($urandom_range(6, 1)) begin
        f = 2'($urandom_range(3));
        add_item(f, VALUE_W'($urandom));
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        results_seen++;
        if (due_results.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("unexpected result transfer: value %0d found %0b last %0b count %0d",
                     m_tdata[VALUE_W-1:0], m_tuser[0], m_tlast,
                     m_tdata[VALUE_W +: COUNT_W]);
        end else begin
          diff_result_t exp_r;
          exp_r = due_results.pop_front();
          if (m_tdata[VALUE_W-1:0] !== exp_r.value || m_tuser[0] !== exp_r.found ||
              m_tlast !== exp_r.last || m_tdata[VALUE_W +: COUNT_W] !== exp_r.count) begin
            errors++;
            if (errors <= 10)
              $display("mismatch at result %0d: expected value %0d found %0b last %0b %s%0d",
                       results_seen, exp_r.value, exp_r.found, exp_r.last, "count ",
                       exp_r.count);
            if (errors <= 10)
              $display("  got value %0d found %0b last %0b count %0d",
                       m_tdata[VALUE_W-1:0], m_tuser[0], m_tlast,
                       m_tdata[VALUE_W +: COUNT_W]);
          end
        end
      end
      s_took = s_tvalid && s_tready;
      if (s_took) begin
        step_set_difference(s_tuser, s_tdata[VALUE_W-1:0]);
        items_to_send.delete(0);
        sent_count++;
      end
      if (s_took || (m_tvalid && m_tready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  // sender: holds an offered transfer until taken
  always @(negedge clk) begin
    if (!rst && (!s_tvalid || s_took)) begin
      if (items_to_send.size() != 0 && !idle_roll(sent_count, 400, 650)) begin
        s_tvalid <= 1'b1;
        s_tuser <= items_to_send[0].func;
        s_tdata <= IN_DATA_W'(items_to_send[0].value);
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // receiver: random stalls, one long hold-off to back the core up
  always @(negedge clk) begin
    if (!rst) begin
      if (hold_left == 0 && !held && results_seen >= HOLD_AT) begin
        held = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= !idle_roll(results_seen, 200, 320);
      end
    end
  end

  initial begin
    clear_sets();
    // empty store, extremes, duplicates, mark before and after offer
    add_item(FUNC_READ, 17'd0);
    add_item(FUNC_OFFER, 17'd0);
    add_item(FUNC_OFFER, 17'd131071);
    add_item(FUNC_OFFER, 17'd5);
    add_item(FUNC_OFFER, 17'd5);
    add_item(FUNC_MARK, 17'd7);
    add_item(FUNC_OFFER, 17'd7);
    add_item(FUNC_OFFER, 17'd9);
    add_item(FUNC_MARK, 17'd9);
    add_item(FUNC_MARK, 17'd7);
    add_item(FUNC_READ, 17'd131071);
    add_item(FUNC_READ, 17'd0);
    add_item(FUNC_READ, 17'd0);
    add_item(FUNC_READ, 17'd0);
    add_item(FUNC_READ, 17'd0);
    // offer below the cursor, then exhausted reads
    add_item(FUNC_OFFER, 17'd3);
    add_item(FUNC_READ, 17'd0);
    add_item(FUNC_READ, 17'd0);
    add_item(FUNC_CLEAR, 17'd131071);
    add_item(FUNC_READ, 17'd0);
    while (items_to_send.size() < 1220) build_run();

    repeat (5) @(negedge clk);
    rst <= 1'b0;
    while (items_to_send.size() != 0 || due_results.size() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
